### design/rcse_pkg.sv
// Shared types and constants of the radial cubic spline evaluator.
// No dependencies; imported by the front, back and top-level modules.
package rcse_pkg;

  localparam int unsigned DATA_W = 32;  // Q16.16 node values and results
  localparam int unsigned RAD_W  = 24;  // Q8.16 radius, step and reciprocal
  localparam int unsigned T_W    = 21;  // t, t^2, t^3 with 20 fraction bits

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_STEP_H         = 3'd0,
    CFG_INV_STEP_H     = 3'd1,
    CFG_NUM_TYPES      = 3'd2,
    CFG_NUM_GRID_NODES = 3'd3,
    CFG_NUM_FUNCS      = 3'd4
  } cfg_idx_e;

  // Effective configuration, already forced into its legal range
  typedef struct packed {
    logic [RAD_W-1:0] step_h;
    logic [RAD_W-1:0] inv_step_h;
    logic [2:0]       num_types;
    logic [8:0]       num_grid_nodes;
    logic [3:0]       num_funcs;
  } cfg_t;

endpackage

### design/rcse_queue.sv
// Two-entry job queue between the front and back of the spline evaluator.
// Generic over the job width; no package dependencies.
module rcse_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (!push_i && pop_i) count_q <= count_q - 2'd1;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

### design/rcse_front.sv
// Front end: accepts items, resolves load addresses, and for evaluate items
// finds edge slot, interval, offset and powers of t. Depends on rcse_pkg.
module rcse_front #(
  parameter int unsigned MAX_TYPES = 4,
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned MAX_FUNCS = 8,
  parameter int unsigned AW        = 15,
  parameter int unsigned EW        = 4,
  parameter int unsigned NW        = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcse_pkg::cfg_t       cfg_i,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func_i,
  input  logic [3:0]           edge_type_i,
  input  logic [7:0]           node_index_i,
  input  logic [2:0]           func_index_i,
  input  logic signed [31:0]   node_value_i,
  input  logic signed [31:0]   node_slope_i,
  input  logic [23:0]          radius_i,
  input  logic [1:0]           type_a_i,
  input  logic [1:0]           type_b_i,
  // job toward the queue
  input  logic                 q_full_i,
  output logic                 push_o,
  output logic                 job_load_o,
  output logic [AW-1:0]        job_waddr_o,
  output logic signed [31:0]   job_value_o,
  output logic signed [31:0]   job_slope_o,
  output logic [EW-1:0]        job_edge_o,
  output logic [NW-1:0]        job_node_o,
  output logic [23:0]          job_x_o,
  output logic [20:0]          job_t_o,
  output logic [20:0]          job_t2_o,
  output logic [20:0]          job_t3_o,
  output logic                 job_oor_o
);
  import rcse_pkg::*;

  localparam int unsigned EDGE_SLOTS = MAX_TYPES * (MAX_TYPES + 1) / 2;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL_N, F_MUL_HN, F_FIX, F_MUL_T, F_MUL_T2, F_MUL_T3, F_PUSH
  } fstate_e;

  fstate_e state_q;

  logic              accept;
  logic              load_ok;
  logic [2:0]        ta, tb, lo, hi, ntm1;
  logic [7:0]        edge_w;
  logic [RAD_W-1:0]  r_q;
  logic [EW-1:0]     edge_q;
  logic [47:0]       prod_q;
  logic [15:0]       n0_q;
  logic [39:0]       hn_q;
  logic [NW-1:0]     n_q;
  logic [23:0]       x_q;
  logic              oor_q;
  logic [T_W-1:0]    t_q, t2_q, t3_q;
  logic [47:0]       xt;
  logic [41:0]       tt;
  logic [41:0]       t2t;
  logic signed [41:0] x0, x1, hs;
  logic [16:0]       n1;
  logic [16:0]       nlast;
  logic [NW-1:0]     n_d;
  logic [23:0]       x_d;
  logic              oor_d;

  assign busy   = (state_q != F_IDLE) || q_full_i;
  assign accept = start && !busy;

  // Drop loads that fall outside the tables
  assign load_ok = (32'(edge_type_i) < EDGE_SLOTS) && (32'(func_index_i) < MAX_FUNCS)
                   && (32'(node_index_i) < MAX_NODES);

  // Symmetric edge slot from the two saturated atom types
  assign ntm1   = cfg_i.num_types - 3'd1;
  assign ta     = ({1'b0, type_a_i} > ntm1) ? ntm1 : {1'b0, type_a_i};
  assign tb     = ({1'b0, type_b_i} > ntm1) ? ntm1 : {1'b0, type_b_i};
  assign lo     = (ta < tb) ? ta : tb;
  assign hi     = (ta < tb) ? tb : ta;
  assign edge_w = ((8'(lo) * ((8'(cfg_i.num_types) << 1) - 8'(lo) - 8'd1)) >> 1) + 8'(hi);

  // Correct the interval estimate by one step and clamp the offset
  assign hs    = $signed({18'd0, cfg_i.step_h});
  assign x0    = $signed({18'd0, r_q}) - $signed({2'd0, hn_q});
  assign nlast = 17'(cfg_i.num_grid_nodes) - 17'd2;
  always_comb begin
    n1 = {1'b0, n0_q};
    x1 = x0;
    if (x0 < 0 && n0_q != 16'd0) begin
      n1 = {1'b0, n0_q} - 17'd1;
      x1 = x0 + hs;
    end else if (x0 >= hs) begin
      n1 = {1'b0, n0_q} + 17'd1;
      x1 = x0 - hs;
    end
    if (x1 < 0)       x_d = 24'd0;
    else if (x1 > hs) x_d = cfg_i.step_h;
    else              x_d = x1[23:0];
    oor_d = 1'b0;
    n_d   = NW'(n1);
    if (n1 > nlast) begin
      n_d   = NW'(nlast);
      x_d   = cfg_i.step_h;
      oor_d = 1'b1;
    end
  end

  assign xt  = x_q * cfg_i.inv_step_h;
  assign tt  = 42'(t_q) * 42'(t_q);
  assign t2t = 42'(t2_q) * 42'(t_q);

  // Sequence one evaluate item through the shared steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept && func_i == FUNC_EVAL) state_q <= F_MUL_N;
        end
        F_MUL_N:  state_q <= F_MUL_HN;
        F_MUL_HN: state_q <= F_FIX;
        F_FIX:    state_q <= F_MUL_T;
        F_MUL_T:  state_q <= F_MUL_T2;
        F_MUL_T2: state_q <= F_MUL_T3;
        F_MUL_T3: state_q <= F_PUSH;
        F_PUSH: begin
          if (!q_full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // Hold item data and intermediate results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q    <= radius_i;
      edge_q <= EW'(edge_w);
    end
    if (state_q == F_MUL_N) prod_q <= 48'(r_q) * 48'(cfg_i.inv_step_h);
    if (state_q == F_MUL_HN) begin
      n0_q <= prod_q[47:32];
      hn_q <= 40'(cfg_i.step_h) * 40'(prod_q[47:32]);
    end
    if (state_q == F_FIX) begin
      n_q   <= n_d;
      x_q   <= x_d;
      oor_q <= oor_d;
    end
    if (state_q == F_MUL_T) begin
      if (xt[47:12] > 36'h100000) t_q <= 21'h100000;
      else                        t_q <= xt[32:12];
    end
    if (state_q == F_MUL_T2) t2_q <= tt[40:20];
    if (state_q == F_MUL_T3) t3_q <= t2t[40:20];
  end

  // Push loads at once, evaluate jobs when finished
  assign push_o = (accept && func_i == FUNC_LOAD && load_ok)
                  || (state_q == F_PUSH && !q_full_i);
  assign job_load_o  = (state_q == F_IDLE);
  assign job_waddr_o = AW'((32'(edge_type_i) * MAX_FUNCS + 32'(func_index_i)) * MAX_NODES
                           + 32'(node_index_i));
  assign job_value_o = node_value_i;
  assign job_slope_o = node_slope_i;
  assign job_edge_o  = edge_q;
  assign job_node_o  = n_q;
  assign job_x_o     = x_q;
  assign job_t_o     = t_q;
  assign job_t2_o    = t2_q;
  assign job_t3_o    = t3_q;
  assign job_oor_o   = oor_q;

endmodule

### design/rcse_back.sv
// Back end: node tables, per-function read sequencer and the spline
// arithmetic pipeline. Depends on rcse_pkg.
module rcse_back #(
  parameter int unsigned MAX_TYPES = 4,
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned MAX_FUNCS = 8,
  parameter int unsigned AW        = 15,
  parameter int unsigned EW        = 4,
  parameter int unsigned NW        = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcse_pkg::cfg_t       cfg_i,
  // job from the queue
  input  logic                 q_empty_i,
  output logic                 pop_o,
  input  logic                 job_load_i,
  input  logic [AW-1:0]        job_waddr_i,
  input  logic signed [31:0]   job_value_i,
  input  logic signed [31:0]   job_slope_i,
  input  logic [EW-1:0]        job_edge_i,
  input  logic [NW-1:0]        job_node_i,
  input  logic [23:0]          job_x_i,
  input  logic [20:0]          job_t_i,
  input  logic [20:0]          job_t2_i,
  input  logic [20:0]          job_t3_i,
  input  logic                 job_oor_i,
  // results
  output logic                 done_o,
  output logic [2:0]           out_func_o,
  output logic signed [31:0]   value_o,
  output logic signed [31:0]   deriv_o,
  output logic                 out_of_range_o,
  output logic                 last_o
);
  import rcse_pkg::*;

  localparam int unsigned EDGE_SLOTS = MAX_TYPES * (MAX_TYPES + 1) / 2;
  localparam int unsigned DEPTH      = EDGE_SLOTS * MAX_FUNCS * MAX_NODES;
  localparam int unsigned KW         = (MAX_FUNCS > 1) ? $clog2(MAX_FUNCS) : 1;
  localparam int unsigned NSTG       = 6;

  typedef struct packed {
    logic [KW-1:0]  k;
    logic           last;
    logic           oor;
    logic [RAD_W-1:0] x;
    logic [T_W-1:0] t;
    logic [T_W-1:0] t2;
    logic [T_W-1:0] t3;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff)      return 32'sh7fff_ffff;
    else if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    else                                    return v[31:0];
  endfunction

  logic signed [DATA_W-1:0] value_mem [DEPTH];
  logic signed [DATA_W-1:0] slope_mem [DEPTH];

  logic             run_q;
  logic [KW-1:0]    k_q;
  logic [AW-1:0]    base_q;
  logic             is_last;
  logic             we;
  side_t            issue_side;
  side_t            job_q;
  side_t            side_q [1:NSTG];
  logic [NSTG:1]    vld_q;

  logic signed [31:0] mv0_q, mv1_q, md0_q, md1_q;
  logic signed [56:0] hd0p_q, hd1p_q, dxp_q;
  logic signed [31:0] p1_v0_q, p1_v1_q, p1_d0_q;
  logic signed [40:0] hd0, hd1;
  logic signed [43:0] a_d, b_d, a_q, b_q;
  logic signed [31:0] p2_v0_q, p2_d0_q, p3_v0_q, p3_d0_q, p4_d0_q, p5_d0_q;
  logic signed [40:0] p2_dx_q, p3_dx_q;
  logic signed [65:0] at2_q, bt3_q, at_q, bt2_q;
  logic signed [67:0] bt2x3;
  logic signed [63:0] val_sum;
  logic signed [48:0] inner_d, inner_q;
  logic signed [31:0] val_q, p5_val_q;
  logic signed [61:0] ph_q, pl_q;
  logic signed [73:0] scaled;
  logic signed [63:0] der_sum;

  // Sequence jobs: loads write once, evaluations issue one function a cycle
  assign pop_o   = !run_q && !q_empty_i;
  assign we      = pop_o && job_load_i;
  assign is_last = (32'(k_q) == 32'(cfg_i.num_funcs) - 32'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      k_q   <= '0;
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-1:1], run_q};
      if (pop_o && !job_load_i) begin
        run_q <= 1'b1;
        k_q   <= '0;
      end else if (run_q) begin
        k_q <= k_q + KW'(1);
        if (is_last) run_q <= 1'b0;
      end
    end
  end

  // Hold job data and walk the table base by one function per cycle
  always_ff @(posedge clk_i) begin
    if (pop_o && !job_load_i) begin
      job_q.k    <= '0;
      job_q.last <= 1'b0;
      job_q.oor  <= job_oor_i;
      job_q.x    <= job_x_i;
      job_q.t    <= job_t_i;
      job_q.t2   <= job_t2_i;
      job_q.t3   <= job_t3_i;
      base_q     <= AW'(32'(job_edge_i) * MAX_FUNCS * MAX_NODES + 32'(job_node_i));
    end else if (run_q) begin
      base_q <= base_q + AW'(MAX_NODES);
    end
  end

  always_comb begin
    issue_side      = job_q;
    issue_side.k    = k_q;
    issue_side.last = is_last;
  end

  // Node tables: one write port, reads of nodes n and n+1
  always_ff @(posedge clk_i) begin
    if (we) begin
      value_mem[job_waddr_i] <= job_value_i;
      slope_mem[job_waddr_i] <= job_slope_i;
    end
    mv0_q <= value_mem[base_q];
    mv1_q <= value_mem[base_q + AW'(1)];
    md0_q <= slope_mem[base_q];
    md1_q <= slope_mem[base_q + AW'(1)];
  end

  // Stage combinational terms
  assign hd0     = $signed(hd0p_q[56:16]);
  assign hd1     = $signed(hd1p_q[56:16]);
  assign a_d     = 44'sd3 * 44'(p1_v1_q) - 44'sd3 * 44'(p1_v0_q) - (44'(hd0) <<< 1) - 44'(hd1);
  assign b_d     = (44'(p1_v0_q) <<< 1) + 44'(hd0) - (44'(p1_v1_q) <<< 1) + 44'(hd1);
  assign bt2x3   = 68'(bt2_q) + (68'(bt2_q) <<< 1);
  assign val_sum = 64'(p3_v0_q) + 64'(p3_dx_q) + 64'($signed(at2_q[65:20]))
                   + 64'($signed(bt3_q[65:20]));
  assign inner_d = 49'($signed(at_q[65:19])) + 49'($signed(bt2x3[67:20]));
  assign scaled  = (74'(ph_q) <<< 12) + 74'(pl_q);
  assign der_sum = 64'(p5_d0_q) + 64'(sat32(64'($signed(scaled[73:16]))));

  // Arithmetic pipeline, one register after each multiply
  always_ff @(posedge clk_i) begin
    side_q[1] <= issue_side;
    for (int i = 2; i <= NSTG; i++) side_q[i] <= side_q[i-1];
    // step scaling of slopes, slope times offset
    hd0p_q  <= $signed({33'd0, cfg_i.step_h}) * 57'(md0_q);
    hd1p_q  <= $signed({33'd0, cfg_i.step_h}) * 57'(md1_q);
    dxp_q   <= 57'(md0_q) * $signed({33'd0, side_q[1].x});
    p1_v0_q <= mv0_q;
    p1_v1_q <= mv1_q;
    p1_d0_q <= md0_q;
    // cubic coefficients
    a_q     <= a_d;
    b_q     <= b_d;
    p2_v0_q <= p1_v0_q;
    p2_d0_q <= p1_d0_q;
    p2_dx_q <= $signed(dxp_q[56:16]);
    // products with powers of t
    at2_q   <= 66'(a_q) * $signed({45'd0, side_q[3].t2});
    bt3_q   <= 66'(b_q) * $signed({45'd0, side_q[3].t3});
    at_q    <= 66'(a_q) * $signed({45'd0, side_q[3].t});
    bt2_q   <= 66'(b_q) * $signed({45'd0, side_q[3].t2});
    p3_v0_q <= p2_v0_q;
    p3_d0_q <= p2_d0_q;
    p3_dx_q <= p2_dx_q;
    // value and derivative numerator
    val_q   <= sat32(val_sum);
    inner_q <= inner_d;
    p4_d0_q <= p3_d0_q;
    // scale by the reciprocal step in two halves
    ph_q     <= 62'(inner_q) * $signed({50'd0, cfg_i.inv_step_h[23:12]});
    pl_q     <= 62'(inner_q) * $signed({50'd0, cfg_i.inv_step_h[11:0]});
    p5_d0_q  <= p4_d0_q;
    p5_val_q <= val_q;
    // result payload
    out_func_o     <= 3'(side_q[NSTG].k);
    value_o        <= p5_val_q;
    deriv_o        <= sat32(der_sum);
    out_of_range_o <= side_q[NSTG].oor;
    last_o         <= side_q[NSTG].last;
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= vld_q[NSTG];
  end

endmodule

### design/radial_cubic_spline_eval_unit.sv
// Top level of the radial cubic spline evaluator: configuration registers,
// front end, job queue and back end. Depends on rcse_pkg and its submodules.
//
//   channel   handshake                   payload
//   item in   start / busy                func_i .. type_b_i
//   config    cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//   result    done_o (one-cycle strobe)   out_func_o .. last_o
//
// A load item is pushed from the front straight into the queue and written by
// the back; it causes no result. An evaluate item steps through the front's states
// (chain of the shared interval and t multipliers), then the back issues one
// table read per function, one per cycle; each result follows its read through
// the registers of the arithmetic pipeline.
// busy is high while the front works on an evaluate item or the two-entry
// queue is full. Reset clears control state only; the node tables are not
// cleared. Results cannot be held off.
module radial_cubic_spline_eval_unit #(
  parameter int unsigned MAX_TYPES = 4,
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned MAX_FUNCS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // items
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  logic [3:0]          edge_type_i,
  input  logic [7:0]          node_index_i,
  input  logic [2:0]          func_index_i,
  input  logic signed [31:0]  node_value_i,
  input  logic signed [31:0]  node_slope_i,
  input  logic [23:0]         radius_i,
  input  logic [1:0]          type_a_i,
  input  logic [1:0]          type_b_i,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  // results
  output logic                done_o,
  output logic [2:0]          out_func_o,
  output logic signed [31:0]  value_o,
  output logic signed [31:0]  deriv_o,
  output logic                out_of_range_o,
  output logic                last_o
);
  import rcse_pkg::*;

  localparam int unsigned EDGE_SLOTS = MAX_TYPES * (MAX_TYPES + 1) / 2;
  localparam int unsigned DEPTH      = EDGE_SLOTS * MAX_FUNCS * MAX_NODES;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned EW         = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int unsigned NW         = $clog2(MAX_NODES);
  localparam int unsigned QW         = 1 + AW + 64 + EW + NW + RAD_W + 3 * T_W + 1;

  logic [23:0] step_h_q, inv_step_h_q;
  logic [2:0]  num_types_q;
  logic [8:0]  num_grid_nodes_q;
  logic [3:0]  num_funcs_q;
  cfg_t        cfg;

  // Configuration writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_h_q         <= 24'd65536;
      inv_step_h_q     <= 24'd65536;
      num_types_q      <= 3'd4;
      num_grid_nodes_q <= 9'd256;
      num_funcs_q      <= 4'd8;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_H:         step_h_q         <= cfg_data_i;
        CFG_INV_STEP_H:     inv_step_h_q     <= cfg_data_i;
        CFG_NUM_TYPES:      num_types_q      <= cfg_data_i[2:0];
        CFG_NUM_GRID_NODES: num_grid_nodes_q <= cfg_data_i[8:0];
        CFG_NUM_FUNCS:      num_funcs_q      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Force registers into their legal ranges
  always_comb begin
    cfg.step_h     = (step_h_q == 24'd0) ? 24'd1 : step_h_q;
    cfg.inv_step_h = (inv_step_h_q == 24'd0) ? 24'd1 : inv_step_h_q;
    if (num_types_q == 3'd0)               cfg.num_types = 3'd1;
    else if (32'(num_types_q) > MAX_TYPES) cfg.num_types = 3'(MAX_TYPES);
    else                                   cfg.num_types = num_types_q;
    if (num_grid_nodes_q < 9'd2)                cfg.num_grid_nodes = 9'd2;
    else if (32'(num_grid_nodes_q) > MAX_NODES) cfg.num_grid_nodes = 9'(MAX_NODES);
    else                                        cfg.num_grid_nodes = num_grid_nodes_q;
    if (num_funcs_q == 4'd0)               cfg.num_funcs = 4'd1;
    else if (32'(num_funcs_q) > MAX_FUNCS) cfg.num_funcs = 4'(MAX_FUNCS);
    else                                   cfg.num_funcs = num_funcs_q;
  end

  logic                push, pop, q_full, q_empty;
  logic [QW-1:0]       q_in, q_out;
  logic                f_load, b_load;
  logic [AW-1:0]       f_waddr, b_waddr;
  logic signed [31:0]  f_value, f_slope, b_value, b_slope;
  logic [EW-1:0]       f_edge, b_edge;
  logic [NW-1:0]       f_node, b_node;
  logic [23:0]         f_x, b_x;
  logic [20:0]         f_t, f_t2, f_t3, b_t, b_t2, b_t3;
  logic                f_oor, b_oor;

  rcse_front #(
    .MAX_TYPES(MAX_TYPES), .MAX_NODES(MAX_NODES), .MAX_FUNCS(MAX_FUNCS),
    .AW(AW), .EW(EW), .NW(NW)
  ) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .start, .busy,
    .func_i, .edge_type_i, .node_index_i, .func_index_i, .node_value_i,
    .node_slope_i, .radius_i, .type_a_i, .type_b_i,
    .q_full_i(q_full), .push_o(push),
    .job_load_o(f_load), .job_waddr_o(f_waddr), .job_value_o(f_value),
    .job_slope_o(f_slope), .job_edge_o(f_edge), .job_node_o(f_node),
    .job_x_o(f_x), .job_t_o(f_t), .job_t2_o(f_t2), .job_t3_o(f_t3),
    .job_oor_o(f_oor)
  );

  // Pack and unpack jobs around the queue
  assign q_in = {f_load, f_waddr, f_value, f_slope, f_edge, f_node, f_x, f_t, f_t2, f_t3, f_oor};
  assign {b_load, b_waddr, b_value, b_slope, b_edge, b_node, b_x, b_t, b_t2, b_t3, b_oor} = q_out;

  rcse_queue #(.DW(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(q_in), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .data_o(q_out)
  );

  rcse_back #(
    .MAX_TYPES(MAX_TYPES), .MAX_NODES(MAX_NODES), .MAX_FUNCS(MAX_FUNCS),
    .AW(AW), .EW(EW), .NW(NW)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .q_empty_i(q_empty), .pop_o(pop),
    .job_load_i(b_load), .job_waddr_i(b_waddr), .job_value_i(b_value),
    .job_slope_i(b_slope), .job_edge_i(b_edge), .job_node_i(b_node),
    .job_x_i(b_x), .job_t_i(b_t), .job_t2_i(b_t2), .job_t3_i(b_t3),
    .job_oor_i(b_oor),
    .done_o, .out_func_o, .value_o, .deriv_o, .out_of_range_o, .last_o
  );

endmodule
